@@ rtl/p2cs_pkg.sv @@
// shared types, constants and the arctangent table of the polar to cartesian scan converter
package p2cs_pkg;

	localparam int RANGE_W   = 24;
	localparam int ANGLE_W   = 32;
	localparam int POINT_W   = 25;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int XY_W      = 36;
	localparam int Z_W       = 34;
	localparam int KINV_W    = 32;
	localparam int PROD_W    = RANGE_W + KINV_W;
	localparam int PRESHIFT  = 24;
	localparam int ROUND_SH  = 8;
	localparam int FIN_W     = XY_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;

	localparam logic [KINV_W-1:0] KINV_Q32 = 32'h9B74EDA8;
	localparam logic signed [FIN_W-1:0] OUT_LIMIT = 37'sd16777215;
	localparam logic signed [FIN_W-1:0] ROUND_ADD = 37'sd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_START = 2'd0,
		REG_ANGLE_STEP  = 2'd1
	} p2cs_reg_t;

	typedef struct packed {
		logic [RANGE_W-1:0] rng;
		logic [ANGLE_W-1:0] angle;
		logic               last;
	} p2cs_item_t;

	function automatic logic [31:0] atan_bau(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0:  t = 32'd536870912;
			5'd1:  t = 32'd316933405;
			5'd2:  t = 32'd167458907;
			5'd3:  t = 32'd85158868;
			5'd4:  t = 32'd42667331;
			5'd5:  t = 32'd21349345;
			5'd6:  t = 32'd10680862;
			5'd7:  t = 32'd5340245;
			5'd8:  t = 32'd2670163;
			5'd9:  t = 32'd1335087;
			5'd10: t = 32'd667544;
			5'd11: t = 32'd333772;
			5'd12: t = 32'd166886;
			5'd13: t = 32'd83443;
			5'd14: t = 32'd41721;
			5'd15: t = 32'd20860;
			5'd16: t = 32'd10430;
			5'd17: t = 32'd5215;
			5'd18: t = 32'd2607;
			5'd19: t = 32'd1303;
			5'd20: t = 32'd651;
			5'd21: t = 32'd325;
			5'd22: t = 32'd162;
			5'd23: t = 32'd81;
			5'd24: t = 32'd40;
			5'd25: t = 32'd20;
			5'd26: t = 32'd10;
			5'd27: t = 32'd5;
			5'd28: t = 32'd2;
			5'd29: t = 32'd1;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/p2cs_front.sv @@
// front end: configuration registers, running angle and sample acceptance
module p2cs_front
	import p2cs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  logic [RANGE_W-1:0]   range_sample,
	input  logic                 first_of_scan,
	input  logic                 last_of_scan,
	input  logic                 q_full,
	output logic                 q_push,
	output p2cs_item_t           q_item
);

	logic [ANGLE_W-1:0] angle_start_q;
	logic [ANGLE_W-1:0] angle_step_q;
	logic [ANGLE_W-1:0] cur_angle_q;
	logic [ANGLE_W-1:0] angle_used;

	assign sample_ready = !q_full;
	assign q_push       = sample_valid && !q_full;
	assign angle_used   = first_of_scan ? angle_start_q : cur_angle_q;

	assign q_item.rng   = range_sample;
	assign q_item.angle = angle_used;
	assign q_item.last  = last_of_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_wr_en) begin
			case (p2cs_reg_t'(cfg_index))
				REG_ANGLE_START: angle_start_q <= cfg_wr_data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_wr_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_angle_q <= '0;
		end else if (q_push) begin
			cur_angle_q <= angle_used + angle_step_q;
		end
	end

endmodule

@@ rtl/p2cs_queue.sv @@
// short queue between the front end and the rotation pipeline
module p2cs_queue
	import p2cs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  p2cs_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output p2cs_item_t pop_item
);

	p2cs_item_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/p2cs_back.sv @@
// back end: gain prescale, quadrant fold, pipelined rotation and output register
module p2cs_back
	import p2cs_pkg::*;
#(
	parameter int CORDIC_STAGES = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_not_empty,
	input  p2cs_item_t                q_item,
	output logic                      q_pop,
	output logic                      point_valid,
	input  logic                      point_ready,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic                      scan_end
);

	logic                    adv;
	logic [PROD_W-1:0]       prod;
	logic                    fold;
	logic [ANGLE_W-1:0]      angle_f;

	logic                    v_s  [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]  x_s  [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]  y_s  [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]   z_s  [CORDIC_STAGES+1];
	logic                    neg_s [CORDIC_STAGES+1];
	logic                    last_s [CORDIC_STAGES+1];

	logic signed [POINT_W-1:0] sx;
	logic signed [POINT_W-1:0] sy;
	logic                    out_valid_q;

	function automatic logic signed [POINT_W-1:0] finish(
		input logic signed [XY_W-1:0] v,
		input logic                   neg
	);
		logic signed [FIN_W-1:0] r;
		r = ($signed({v[XY_W-1], v}) + ROUND_ADD) >>> ROUND_SH;
		if (neg) begin
			r = -r;
		end
		if (r > OUT_LIMIT) begin
			r = OUT_LIMIT;
		end else if (r < -OUT_LIMIT) begin
			r = -OUT_LIMIT;
		end
		return r[POINT_W-1:0];
	endfunction

	assign adv   = !out_valid_q || point_ready;
	assign q_pop = adv;

	assign prod    = PROD_W'(q_item.rng) * PROD_W'(KINV_Q32);
	assign fold    = (q_item.angle[ANGLE_W-1:ANGLE_W-2] == 2'b01) ||
	                 (q_item.angle[ANGLE_W-1:ANGLE_W-2] == 2'b10);
	assign angle_f = {q_item.angle[ANGLE_W-1] ^ fold, q_item.angle[ANGLE_W-2:0]};

	// prescale and fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= $signed(XY_W'(prod[PROD_W-1:PRESHIFT]));
			y_s[0]    <= '0;
			z_s[0]    <= Z_W'($signed(angle_f));
			neg_s[0]  <= fold;
			last_s[0] <= q_item.last;
		end
	end

	// rotation stages
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		localparam logic signed [Z_W-1:0] T = $signed(Z_W'(atan_bau(5'(k))));
		logic signed [XY_W-1:0] xsh;
		logic signed [XY_W-1:0] ysh;

		assign xsh = x_s[k] >>> k;
		assign ysh = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_s[k][Z_W-1]) begin
					x_s[k+1] <= x_s[k] - ysh;
					y_s[k+1] <= y_s[k] + xsh;
					z_s[k+1] <= z_s[k] - T;
				end else begin
					x_s[k+1] <= x_s[k] + ysh;
					y_s[k+1] <= y_s[k] - xsh;
					z_s[k+1] <= z_s[k] + T;
				end
				neg_s[k+1]  <= neg_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	assign sx = finish(x_s[CORDIC_STAGES], neg_s[CORDIC_STAGES]);
	assign sy = finish(y_s[CORDIC_STAGES], neg_s[CORDIC_STAGES]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_x  <= sx;
			point_y  <= sy;
			scan_end <= last_s[CORDIC_STAGES];
		end
	end

	assign point_valid = out_valid_q;

endmodule

@@ rtl/polar_to_cartesian_scan.sv @@
// top level of the polar to cartesian scan converter
//
// channel   direction  handshake                    payload
// sample    in         sample_valid/sample_ready    range_sample, first_of_scan, last_of_scan
// point     out        point_valid/point_ready      point_x, point_y, scan_end
// cfg       in         cfg_wr_en                    cfg_index, cfg_wr_data
//
// one sample per cycle sustained while point_ready stays high; point_valid rises once the
// accepted sample has passed the queue, the prescale register, one register per rotation
// stage and the output register. reset clears the configuration registers, the queue
// pointers, the running angle and all valid flags.
// a stalled point freezes the rotation pipeline; the four-entry queue keeps taking
// samples until it fills, then sample_ready drops.
module polar_to_cartesian_scan
	import p2cs_pkg::*;
#(
	parameter int CORDIC_STAGES = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_wr_data,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  logic [RANGE_W-1:0]        range_sample,
	input  logic                      first_of_scan,
	input  logic                      last_of_scan,
	output logic                      point_valid,
	input  logic                      point_ready,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic                      scan_end
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_not_empty;
	p2cs_item_t push_item;
	p2cs_item_t pop_item;

	p2cs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.range_sample  (range_sample),
		.first_of_scan (first_of_scan),
		.last_of_scan  (last_of_scan),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	p2cs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	p2cs_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.scan_end    (scan_end)
	);

endmodule
